[rtl/tiny_risc_decode_execute_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the tiny RISC decode/execute block
// Concurrent checks on clk_i with reset masking; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TINY_RISC_DECODE_EXECUTE_TOP_MACROS_SVH
`define TINY_RISC_DECODE_EXECUTE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TRDE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define TRDE_ASSERT_NEVER(name, expr) \
  `TRDE_ASSERT(name, !(expr))
`else
`define TRDE_ASSERT(name, prop)
`define TRDE_ASSERT_NEVER(name, expr)
`endif

`endif

[rtl/trde_pkg.sv]
// ----------------------------------------------------------------------------
// trde_pkg
// Types, opcodes and helpers shared by the decode/execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trde_pkg;

  localparam int NUM_REGS = 32;
  localparam int RegAw    = $clog2(NUM_REGS);
  localparam int XLEN     = 32;

  localparam logic [XLEN-1:0] UIMM_MASK = 32'hFFFF_F000;

  localparam int IN_TDATA_W = 40;

  typedef enum logic [6:0] {
    OP_LUI    = 7'h01,
    OP_AUIPC  = 7'h02,
    OP_JAL    = 7'h03,
    OP_JALR   = 7'h04,
    OP_BEQ    = 7'h05,
    OP_LBU    = 7'h0E,
    OP_SB     = 7'h10,
    OP_ADDI   = 7'h13,
    OP_EBREAK = 7'h27
  } opcode_e;

  typedef enum logic [1:0] {
    ST_EXEC    = 2'd0,
    ST_EBREAK  = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef struct packed {
    logic             en;
    logic [RegAw-1:0] addr;
    logic [XLEN-1:0]  data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLEN-1:0]  pc;
    logic             halt;
    logic             pend;
    logic [RegAw-1:0] dest;
  } core_state_t;

  // Last member sits in the lowest bits, so fetch_addr packs first.
  typedef struct packed {
    logic            halted;
    status_e         status;
    logic [7:0]      store_byte;
    logic            store_valid;
    logic            load_request;
    logic [XLEN-1:0] mem_addr;
    logic [XLEN-1:0] fetch_addr;
  } result_t;

  localparam int RES_W       = $bits(result_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  function automatic logic [XLEN-1:0] sext12(input logic [11:0] v);
    return {{(XLEN-12){v[11]}}, v};
  endfunction

  function automatic logic [XLEN-1:0] sext20(input logic [19:0] v);
    return {{(XLEN-20){v[19]}}, v};
  endfunction

endpackage

`default_nettype wire

[rtl/tiny_risc_decode_execute_top.sv]
// ----------------------------------------------------------------------------
// tiny_risc_decode_execute_top
// Single-pass core for a small RISC-V-like subset with a result register.
// ----------------------------------------------------------------------------
// Timing: an item is held in the input register, then executed into the result
// register that drives the master side. Throughput: one item per cycle unless
// the master side stalls; the register file is read while the item enters the
// input register, with bypass from the write of the item ahead.
// Reset: PC goes to zero, halt and pending-load flags clear, and the register
// file valid bits clear at once so every register reads zero.
`timescale 1ns / 1ps
`default_nettype none

`include "tiny_risc_decode_execute_top_macros.svh"

module tiny_risc_decode_execute_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: start_pc.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [trde_pkg::XLEN-1:0]        cfg_data_i,
  // Input stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: instr_word [31:0], load_byte [39:32]
  input  logic [trde_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: req_type [0]
  input  logic                             s_axis_tuser,
  // Result stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: fetch_addr [31:0], mem_addr [63:32], load_request [64],
  // store_valid [65], store_byte [73:66], status [75:74], halted [76], zero pad
  output logic [trde_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import trde_pkg::*;

  logic            s1_valid_q;
  logic            s1_req_q;
  logic [XLEN-1:0] s1_instr_q;
  logic [7:0]      s1_byte_q;
  logic            in_fire, exec_fire;

  logic [XLEN-1:0] rs1_val, rs2_val;
  core_state_t     state_q, state_d;
  rf_wr_t          wr, wr_raw;
  result_t         res_q, res_d;

  assign cfg_ready_o   = 1'b1;
  assign exec_fire     = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || exec_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  trde_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_fire),
    .raddr1_i (s_axis_tdata[12 +: RegAw]),
    .raddr2_i (s_axis_tdata[7 +: RegAw]),
    .wr_i     (wr),
    .rdata1_o (rs1_val),
    .rdata2_o (rs2_val)
  );

  trde_exec u_exec (
    .req_i   (s1_req_q),
    .instr_i (s1_instr_q),
    .byte_i  (s1_byte_q),
    .rs1_i   (rs1_val),
    .rs2_i   (rs2_val),
    .state_i (state_q),
    .state_o (state_d),
    .wr_o    (wr_raw),
    .res_o   (res_d)
  );

  // Register file writes only take effect when the item actually executes.
  always_comb begin
    wr    = wr_raw;
    wr.en = wr_raw.en && exec_fire;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q   <= s_axis_tuser;
      s1_instr_q <= s_axis_tdata[XLEN-1:0];
      s1_byte_q  <= s_axis_tdata[XLEN +: 8];
    end
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      state_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (exec_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        state_q.pc <= cfg_data_i;
      end else if (exec_fire) begin
        state_q <= state_d;
      end
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-RES_W){1'b0}}, res_q};

  `TRDE_ASSERT(a_halt_sticky, state_q.halt |=> state_q.halt)
  `TRDE_ASSERT(a_res_halt_match, m_axis_tvalid |-> (res_q.halted == state_q.halt))
  `TRDE_ASSERT(a_load_req_pending, (m_axis_tvalid && res_q.load_request) |-> state_q.pend)
  `TRDE_ASSERT_NEVER(a_no_x0_write, wr.en && (wr.addr == '0))

endmodule

`default_nettype wire

[rtl/trde_regfile.sv]
// ----------------------------------------------------------------------------
// trde_regfile
// 32-entry register file with two registered read ports, write bypass and
// per-entry valid bits so that unwritten registers read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trde_regfile (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [trde_pkg::RegAw-1:0] raddr1_i,
  input  logic [trde_pkg::RegAw-1:0] raddr2_i,
  input  trde_pkg::rf_wr_t          wr_i,
  output logic [trde_pkg::XLEN-1:0] rdata1_o,
  output logic [trde_pkg::XLEN-1:0] rdata2_o
);
  import trde_pkg::*;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_BYP
  } src_e;

  logic [XLEN-1:0]     mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] valid_q;
  logic [XLEN-1:0]     mem1_q, mem2_q, byp_q;
  src_e                sel1_q, sel1_d, sel2_q, sel2_d;
  logic                wr_ok;

  // x0 is never stored; it always reads zero.
  assign wr_ok = wr_i.en && (wr_i.addr != '0);

  always_comb begin
    if (raddr1_i == '0) begin
      sel1_d = SRC_ZERO;
    end else if (wr_ok && (wr_i.addr == raddr1_i)) begin
      sel1_d = SRC_BYP;
    end else if (valid_q[raddr1_i]) begin
      sel1_d = SRC_MEM;
    end else begin
      sel1_d = SRC_ZERO;
    end
  end

  always_comb begin
    if (raddr2_i == '0) begin
      sel2_d = SRC_ZERO;
    end else if (wr_ok && (wr_i.addr == raddr2_i)) begin
      sel2_d = SRC_BYP;
    end else if (valid_q[raddr2_i]) begin
      sel2_d = SRC_MEM;
    end else begin
      sel2_d = SRC_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem1_q <= mem_q[raddr1_i];
      mem2_q <= mem_q[raddr2_i];
      byp_q  <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sel1_q  <= SRC_ZERO;
      sel2_q  <= SRC_ZERO;
    end else begin
      if (wr_ok) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        sel1_q <= sel1_d;
        sel2_q <= sel2_d;
      end
    end
  end

  always_comb begin
    case (sel1_q)
      SRC_MEM: rdata1_o = mem1_q;
      SRC_BYP: rdata1_o = byp_q;
      default: rdata1_o = '0;
    endcase
    case (sel2_q)
      SRC_MEM: rdata2_o = mem2_q;
      SRC_BYP: rdata2_o = byp_q;
      default: rdata2_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/trde_exec.sv]
// ----------------------------------------------------------------------------
// trde_exec
// Decode and execute of one item: next state, register write and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trde_exec (
  input  logic                      req_i,
  input  logic [trde_pkg::XLEN-1:0] instr_i,
  input  logic [7:0]                byte_i,
  input  logic [trde_pkg::XLEN-1:0] rs1_i,
  input  logic [trde_pkg::XLEN-1:0] rs2_i,
  input  trde_pkg::core_state_t     state_i,
  output trde_pkg::core_state_t     state_o,
  output trde_pkg::rf_wr_t          wr_o,
  output trde_pkg::result_t         res_o
);
  import trde_pkg::*;

  opcode_e          op;
  logic [RegAw-1:0] rd;
  logic [XLEN-1:0]  imm, uimm, sum_rs1, next_seq, offset, target;

  assign op       = opcode_e'(instr_i[6:0]);
  assign rd       = instr_i[7 +: RegAw];
  assign imm      = sext12(instr_i[31:20]);
  assign uimm     = instr_i & UIMM_MASK;
  assign sum_rs1  = rs1_i + imm;
  assign next_seq = state_i.pc + XLEN'(4);
  assign target   = state_i.pc + offset;

  // One PC-relative adder serves AUIPC, JAL and BEQ.
  always_comb begin
    unique case (op)
      OP_AUIPC: offset = uimm;
      OP_JAL:   offset = sext20(instr_i[31:12]) << 1;
      default:  offset = {imm[XLEN-2:0], 1'b0};
    endcase
  end

  always_comb begin
    state_o = state_i;
    wr_o    = '0;
    res_o   = '0;
    if (state_i.halt || (req_i != state_i.pend)) begin
      res_o.status = ST_IGNORED;
    end else if (req_i) begin
      wr_o.en     = (state_i.dest != '0);
      wr_o.addr   = state_i.dest;
      wr_o.data   = {{(XLEN-8){1'b0}}, byte_i};
      state_o.pend = 1'b0;
    end else begin
      state_o.pc = next_seq;
      wr_o.addr  = rd;
      unique case (op)
        OP_LUI: begin
          wr_o.en   = (rd != '0);
          wr_o.data = uimm;
        end
        OP_AUIPC: begin
          wr_o.en   = (rd != '0);
          wr_o.data = target;
        end
        OP_JAL: begin
          wr_o.en    = (rd != '0);
          wr_o.data  = next_seq;
          state_o.pc = target;
        end
        OP_JALR: begin
          wr_o.en    = (rd != '0);
          wr_o.data  = next_seq;
          state_o.pc = {sum_rs1[XLEN-1:1], 1'b0};
        end
        OP_BEQ: begin
          if (rs1_i == rs2_i) begin
            state_o.pc = target;
          end
        end
        OP_LBU: begin
          res_o.mem_addr     = sum_rs1;
          res_o.load_request = 1'b1;
          state_o.pend       = 1'b1;
          state_o.dest       = rd;
        end
        OP_SB: begin
          res_o.mem_addr    = sum_rs1;
          res_o.store_valid = 1'b1;
          res_o.store_byte  = rs2_i[7:0];
        end
        OP_ADDI: begin
          wr_o.en   = (rd != '0);
          wr_o.data = sum_rs1;
        end
        OP_EBREAK: begin
          state_o.halt = 1'b1;
          res_o.status = ST_EBREAK;
        end
        default: begin
          state_o.halt = 1'b1;
          res_o.status = ST_ILLEGAL;
        end
      endcase
    end
    res_o.fetch_addr = state_o.pc;
    res_o.halted     = state_o.halt;
  end

endmodule

`default_nettype wire

[tb/sv/tiny_risc_decode_execute_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_risc_decode_execute_top_tb
// Drives instruction and load-data transactions into the decode/execute core
// and keeps a shadow copy of its PC, register file and halt state to predict
// every result. Results are checked field by field in arrival order. The
// start_pc register is rewritten between phases, and the halt comes last
// because only a reset clears it.
// ----------------------------------------------------------------------------

module tiny_risc_decode_execute_top_tb;
  import trde_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [XLEN-1:0]        cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  tiny_risc_decode_execute_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow architectural state.
  logic [XLEN-1:0] arch_pc;
  logic [XLEN-1:0] arch_regs [NUM_REGS];
  logic            arch_halted;
  logic            load_wait;
  logic [4:0]      load_rd;

  result_t retire_q [$];
  bit      no_stalls;
  int      mismatches;
  int      items_sent;
  int      items_ignored;
  int      results_checked;
  int      pc_writes;
  int      cycle_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) m_axis_tready <= no_stalls || ($urandom_range(0, 99) >= 25);

  function automatic void write_gpr(input logic [4:0] idx, input logic [XLEN-1:0] val);
    if (idx != 5'd0) arch_regs[idx] = val;
  endfunction

  // Executes one transaction on the shadow state and returns its result.
  function automatic result_t retire_item(input logic req, input logic [31:0] word,
                                          input logic [7:0] lb);
    result_t         r;
    logic [4:0]      rd;
    logic [4:0]      rs1;
    logic [XLEN-1:0] imm;
    logic [XLEN-1:0] next_pc;
    logic [XLEN-1:0] target;
    r        = '0;
    r.status = ST_EXEC;
    rd       = word[11:7];
    rs1      = word[16:12];
    imm      = {{20{word[31]}}, word[31:20]};
    if (arch_halted || (req != load_wait)) begin
      r.status = ST_IGNORED;
      items_ignored++;
    end else if (req) begin
      write_gpr(load_rd, {24'd0, lb});
      load_wait = 1'b0;
    end else begin
      next_pc = arch_pc + 32'd4;
      case (word[6:0])
        OP_LUI:   write_gpr(rd, word & UIMM_MASK);
        OP_AUIPC: write_gpr(rd, arch_pc + (word & UIMM_MASK));
        OP_JAL: begin
          write_gpr(rd, arch_pc + 32'd4);
          next_pc = arch_pc + {{11{word[31]}}, word[31:12], 1'b0};
        end
        OP_JALR: begin
          // The target is formed before rd is written, since rd may equal rs1.
          target = (arch_regs[rs1] + imm) & ~32'd1;
          write_gpr(rd, arch_pc + 32'd4);
          next_pc = target;
        end
        OP_BEQ: begin
          if (arch_regs[rs1] == arch_regs[rd]) next_pc = arch_pc + {imm[30:0], 1'b0};
        end
        OP_LBU: begin
          r.mem_addr     = arch_regs[rs1] + imm;
          r.load_request = 1'b1;
          load_wait      = 1'b1;
          load_rd        = rd;
        end
        OP_SB: begin
          r.mem_addr    = arch_regs[rs1] + imm;
          r.store_valid = 1'b1;
          r.store_byte  = arch_regs[rd][7:0];
        end
        OP_ADDI: write_gpr(rd, arch_regs[rs1] + imm);
        OP_EBREAK: begin
          arch_halted = 1'b1;
          r.status    = ST_EBREAK;
        end
        default: begin
          arch_halted = 1'b1;
          r.status    = ST_ILLEGAL;
        end
      endcase
      arch_pc = next_pc;
    end
    r.fetch_addr = arch_pc;
    r.halted     = arch_halted;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(input opcode_e op, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [11:0] imm);
    return {imm, 3'($urandom), rs1, rd, op};
  endfunction

  function automatic opcode_e pick_op();
    case ($urandom_range(0, 7))
      0:       return OP_LUI;
      1:       return OP_AUIPC;
      2:       return OP_JAL;
      3:       return OP_JALR;
      4:       return OP_BEQ;
      5:       return OP_LBU;
      6:       return OP_SB;
      default: return OP_ADDI;
    endcase
  endfunction

  task automatic send_item(input logic req, input logic [31:0] word, input logic [7:0] lb);
    while (!no_stalls && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {lb, word};
    do @(posedge clk_i); while (!s_axis_tready);
    retire_q.push_back(retire_item(req, word, lb));
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (retire_q.size() != 0);
  endtask

  // Only called with the core idle; a write also reloads the PC.
  task automatic write_start_pc(input logic [XLEN-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    arch_pc     = value;
    pc_writes++;
  endtask

  // Mostly well-formed traffic: a load is normally followed by its data byte.
  task automatic send_random_item();
    logic [31:0] word;
    logic [7:0]  lb;
    word = $urandom;
    lb   = 8'($urandom_range(0, 255));
    if (load_wait) begin
      send_item($urandom_range(0, 9) != 0, word, lb);
    end else if ($urandom_range(0, 19) == 0) begin
      send_item(1'b1, word, lb);
    end else begin
      word[6:0] = pick_op();
      if (word[6:0] == OP_BEQ && $urandom_range(0, 1) == 1) word[16:12] = word[11:7];
      send_item(1'b0, word, lb);
    end
  endtask

  task automatic test_opcodes();
    send_item(1'b0, enc_i(OP_ADDI, 5'd1, 5'd0, 12'h7FF), 8'h00);
    send_item(1'b0, enc_i(OP_ADDI, 5'd2, 5'd0, 12'h800), 8'hFF);
    send_item(1'b0, enc_i(OP_ADDI, 5'd0, 5'd1, 12'h001), 8'h00);
    send_item(1'b0, {20'hFFFFF, 5'd3, OP_LUI}, 8'h00);
    send_item(1'b0, {20'h80000, 5'd4, OP_AUIPC}, 8'h00);
    send_item(1'b0, enc_i(OP_BEQ, 5'd0, 5'd0, 12'h008), 8'h00);
    send_item(1'b0, enc_i(OP_BEQ, 5'd2, 5'd1, 12'hFFC), 8'h00);
    send_item(1'b0, {20'h7FFFF, 5'd5, OP_JAL}, 8'h00);
    send_item(1'b0, {20'h80000, 5'd6, OP_JAL}, 8'h00);
    // x1 holds an odd value, so the JALR target has bit 0 cleared.
    send_item(1'b0, enc_i(OP_JALR, 5'd7, 5'd1, 12'h000), 8'h00);
    send_item(1'b0, enc_i(OP_JALR, 5'd7, 5'd7, 12'hFFF), 8'h00);
    send_item(1'b0, enc_i(OP_SB, 5'd1, 5'd2, 12'h7FF), 8'h00);
    send_item(1'b0, enc_i(OP_LBU, 5'd8, 5'd1, 12'h800), 8'h00);
    send_item(1'b0, enc_i(OP_ADDI, 5'd9, 5'd1, 12'h001), 8'h00);
    send_item(1'b1, 32'($urandom), 8'hFF);
    send_item(1'b1, 32'($urandom), 8'h5A);
    send_item(1'b0, enc_i(OP_LBU, 5'd0, 5'd0, 12'h000), 8'h00);
    send_item(1'b1, 32'($urandom), 8'h00);
    send_item(1'b0, enc_i(OP_ADDI, 5'd9, 5'd8, 12'h001), 8'h00);
    send_item(1'b0, enc_i(OP_SB, 5'd8, 5'd0, 12'h000), 8'h00);
    send_item(1'b0, enc_i(OP_SB, 5'd0, 5'd9, 12'h000), 8'h00);
  endtask

  task automatic test_start_pc_settings();
    logic [XLEN-1:0] pcs [4];
    pcs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'($urandom)};
    foreach (pcs[i]) begin
      wait_idle();
      write_start_pc(pcs[i]);
      repeat (12) send_random_item();
    end
  endtask

  task automatic test_random_program(input int count, input bit steady);
    no_stalls = steady;
    repeat (count) send_random_item();
    no_stalls = 1'b0;
  endtask

  // Halt is sticky until reset, so this runs last.
  task automatic test_halt();
    logic [31:0] word;
    if (load_wait) send_item(1'b1, 32'($urandom), 8'($urandom));
    word = $urandom;
    // No defined opcode has bit 6 set, so such a value is always unknown.
    if ($urandom_range(0, 1) == 1) word[6:0] = OP_EBREAK;
    else word[6] = 1'b1;
    send_item(1'b0, word, 8'($urandom));
    repeat (20) send_item(1'($urandom), 32'($urandom), 8'($urandom));
  endtask

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[RES_W-1:0]);
      if (retire_q.size() == 0) begin
        $error("result transaction with no prediction waiting: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = retire_q.pop_front();
        results_checked++;
        if (got.fetch_addr !== want.fetch_addr) begin
          $error("fetch_addr: expected %h, got %h", want.fetch_addr, got.fetch_addr);
          mismatches++;
        end
        if (got.mem_addr !== want.mem_addr) begin
          $error("mem_addr: expected %h, got %h", want.mem_addr, got.mem_addr);
          mismatches++;
        end
        if (got.load_request !== want.load_request) begin
          $error("load_request: expected %b, got %b", want.load_request, got.load_request);
          mismatches++;
        end
        if (got.store_valid !== want.store_valid) begin
          $error("store_valid: expected %b, got %b", want.store_valid, got.store_valid);
          mismatches++;
        end
        if (got.store_byte !== want.store_byte) begin
          $error("store_byte: expected %h, got %h", want.store_byte, got.store_byte);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.halted !== want.halted) begin
          $error("halted: expected %b, got %b", want.halted, got.halted);
          mismatches++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0) begin
          $error("tdata pad: expected 0, got %h", m_axis_tdata[OUT_TDATA_W-1:RES_W]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    arch_pc       = '0;
    arch_halted   = 1'b0;
    load_wait     = 1'b0;
    load_rd       = '0;
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_opcodes();
    test_start_pc_settings();
    test_random_program(1300, 1'b0);
    test_random_program(450, 1'b1);
    test_halt();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("tb: %0d transactions sent, %0d of them ignored by the core",
             items_sent, items_ignored);
    $display("tb: %0d results checked across %0d start_pc settings, ending in halt",
             results_checked, pc_writes);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[tiny_risc_decode_execute_top.f]
+incdir+rtl
rtl/trde_pkg.sv
rtl/trde_regfile.sv
rtl/trde_exec.sv
rtl/tiny_risc_decode_execute_top.sv
tb/sv/tiny_risc_decode_execute_top_tb.sv
